@@ hw/rtl/rds_pkg.sv @@
// ----------------------------------------------------------------------------
// rds_pkg
// Shared types and constants for the row delimiter splitter.
// ----------------------------------------------------------------------------
package rds_pkg;

    localparam int MAX_DELIM_DEFAULT   = 8;
    localparam int OFFSET_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH         = 4;
    localparam int CFG_DATA_W          = 64;
    localparam int FIELD_W             = 32;

    localparam logic [CFG_DATA_W-1:0] DELIM_BYTES_RESET = 64'd10;
    localparam logic [3:0]            DELIM_LEN_RESET   = 4'd1;

    typedef enum logic {
        CFG_DELIM_BYTES  = 1'b0,
        CFG_DELIM_LENGTH = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_RECORD         = 2'd0,
        KIND_END_COMPLETE   = 2'd1,
        KIND_END_INCOMPLETE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               last;
    } result_t;

    // Results produced by one byte, oldest in res0.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

@@ hw/rtl/row_delimiter_splitter_top.sv @@
// ----------------------------------------------------------------------------
// row_delimiter_splitter_top
// Splits a byte stream into records ended by a 1 to 8 byte delimiter and
// reports record start/length plus a summary at each buffer end.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  cfg     | cfg_write            | cfg_index, cfg_data
//  in      | in_valid / in_ready  | data_byte, first_of_buffer, base_offset,
//          |                      | last_of_buffer, buffer_at_eof
//  out     | out_valid / out_ready| result_kind, record_start, record_length,
//          |                      | last_result
//
//  One byte per cycle while the queue has room; results go through the input
//  register and the queue. A byte yields 0, 1 or 2 results, two when it
//  closes a record on a buffer's last byte; the output drains one per cycle.
//  Rate is set by the 4-entry result queue and its single read port.
//  Reset clears the window, position and queue; no clearing pass is needed.
//  out_ready low fills the queue until it lacks room for two, then in_ready drops.
// ----------------------------------------------------------------------------
module row_delimiter_splitter_top #(
    parameter int MAX_DELIMITER_BYTES = rds_pkg::MAX_DELIM_DEFAULT,
    parameter int OFFSET_BITS         = rds_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [rds_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      data_byte,
    input  logic                            first_of_buffer,
    input  logic [31:0]                     base_offset,
    input  logic                            last_of_buffer,
    input  logic                            buffer_at_eof,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      result_kind,
    output logic [31:0]                     record_start,
    output logic [31:0]                     record_length,
    output logic                            last_result
);

    rds_pkg::push_t   push;
    rds_pkg::result_t head;
    logic             room;

    rds_core #(
        .MAX_DELIMITER_BYTES (MAX_DELIMITER_BYTES),
        .OFFSET_BITS         (OFFSET_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .first_of_buffer (first_of_buffer),
        .base_offset     (base_offset),
        .last_of_buffer  (last_of_buffer),
        .buffer_at_eof   (buffer_at_eof),
        .room            (room),
        .push            (push)
    );

    rds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign result_kind   = head.kind;
    assign record_start  = head.start;
    assign record_length = head.length;
    assign last_result   = head.last;

endmodule

@@ hw/rtl/rds_core.sv @@
// ----------------------------------------------------------------------------
// rds_core
// Input register, delimiter window compare, position tracking and result
// generation for one byte per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module rds_core #(
    parameter int MAX_DELIMITER_BYTES = rds_pkg::MAX_DELIM_DEFAULT,
    parameter int OFFSET_BITS         = rds_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [rds_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      data_byte,
    input  logic                            first_of_buffer,
    input  logic [31:0]                     base_offset,
    input  logic                            last_of_buffer,
    input  logic                            buffer_at_eof,
    input  logic                            room,
    output rds_pkg::push_t                  push
);

    localparam int MD  = MAX_DELIMITER_BYTES;
    localparam int OW  = OFFSET_BITS;
    localparam int FW  = $clog2(MD + 1);
    localparam int WW  = MD * 8;
    localparam logic [OW-1:0] POS_MAX = '1;
    localparam logic [FW-1:0] FILL_MAX = FW'(MD);

    // configuration
    logic [rds_pkg::CFG_DATA_W-1:0] delim_reg;
    logic [3:0]                     dlen_reg;

    // input register
    logic        vld_reg;
    logic [7:0]  byte_reg;
    logic        first_reg;
    logic [31:0] base_reg;
    logic        last_reg;
    logic        eof_reg;

    // splitter state
    logic [WW-1:0] win_reg,   win_next;
    logic [FW-1:0] fill_reg,  fill_next;
    logic [OW-1:0] pos_reg,   pos_next;
    logic [OW-1:0] start_reg, start_next;

    logic          fire;
    logic [3:0]    len_eff;
    logic [63:0]   base_wide;
    logic [OW-1:0] pos0;
    logic [OW-1:0] start0;
    logic [WW-1:0] win0;
    logic [FW-1:0] fill0;
    logic [WW-1:0] window;
    logic [FW-1:0] fill1;
    logic [OW-1:0] next_pos;
    logic [OW-1:0] rec_len;
    logic          match;
    logic          close;
    logic [2:0]    lane;

    assign fire     = vld_reg && room;
    assign in_ready = !vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= rds_pkg::DELIM_BYTES_RESET;
            dlen_reg  <= rds_pkg::DELIM_LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (rds_pkg::cfg_index_t'(cfg_index))
                rds_pkg::CFG_DELIM_BYTES:  delim_reg <= cfg_data;
                rds_pkg::CFG_DELIM_LENGTH: dlen_reg  <= cfg_data[3:0];
                default:                   dlen_reg  <= dlen_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg  <= data_byte;
            first_reg <= first_of_buffer;
            base_reg  <= base_offset;
            last_reg  <= last_of_buffer;
            eof_reg   <= buffer_at_eof;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            fill_reg  <= '0;
            pos_reg   <= '0;
            start_reg <= '0;
        end
        else if (fire)
        begin
            win_reg   <= win_next;
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
        end
    end

    // effective delimiter length: 0 acts as 1, anything past the window as max
    always_comb
    begin
        if (dlen_reg == 4'd0)
            len_eff = 4'd1;
        else if (32'(dlen_reg) > MD)
            len_eff = 4'(MD);
        else
            len_eff = dlen_reg;
    end

    // buffer start reloads position and clears the window
    always_comb
    begin
        base_wide = 64'(base_reg);
        if (first_reg)
        begin
            pos0   = (base_wide > 64'(POS_MAX)) ? POS_MAX : OW'(base_wide);
            start0 = pos0;
            win0   = '0;
            fill0  = '0;
        end
        else
        begin
            pos0   = pos_reg;
            start0 = start_reg;
            win0   = win_reg;
            fill0  = fill_reg;
        end
    end

    generate
        if (MD > 1)
        begin : g_shift
            assign window = {win0[WW-9:0], byte_reg};
        end
        else
        begin : g_single
            assign window = byte_reg;
        end
    endgenerate

    assign fill1    = (fill0 < FILL_MAX) ? fill0 + FW'(1) : FILL_MAX;
    assign next_pos = (pos0 != POS_MAX) ? pos0 + OW'(1) : POS_MAX;
    assign rec_len  = (next_pos >= start0) ? next_pos - start0 : '0;

    // newest window byte k pairs with delimiter byte len-1-k
    always_comb
    begin
        match = (4'(fill1) >= len_eff);
        lane  = '0;
        for (int k = 0; k < MD; k++)
        begin
            lane = 3'(len_eff - 4'd1 - 4'(k));
            if ((4'(k) < len_eff) &&
                (window[k*8 +: 8] != delim_reg[lane*8 +: 8]))
                match = 1'b0;
        end
    end

    assign close = match || (last_reg && eof_reg);

    always_comb
    begin
        win_next   = window;
        pos_next   = next_pos;
        start_next = close ? next_pos : start0;
        fill_next  = close ? '0 : fill1;
    end

    always_comb
    begin
        push            = '0;
        push.res0.start = 32'(start0);
        push.res0.length = 32'(rec_len);
        push.res1.kind  = rds_pkg::KIND_END_COMPLETE;
        push.res1.start = 32'(next_pos);
        push.res1.last  = 1'b1;
        if (fire)
        begin
            if (close && last_reg)
            begin
                // record (delimiter or trailing fragment at end of file) then summary
                push.count     = 2'd2;
                push.res0.kind = rds_pkg::KIND_RECORD;
            end
            else if (match)
            begin
                push.count     = 2'd1;
                push.res0.kind = rds_pkg::KIND_RECORD;
                push.res0.last = 1'b1;
            end
            else if (last_reg)
            begin
                // open fragment left unconsumed
                push.count       = 2'd1;
                push.res0.kind   = rds_pkg::KIND_END_INCOMPLETE;
                push.res0.length = '0;
                push.res0.last   = 1'b1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("window fill past delimiter capacity");

    a_eof_closes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_reg && eof_reg |=> fill_reg == '0 && start_reg == pos_reg)
        else $error("end of file left an open record");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.res0.kind == rds_pkg::KIND_RECORD &&
                               push.res1.kind == rds_pkg::KIND_END_COMPLETE)
        else $error("two results must be record then complete summary");

    a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> push.count == 2'd0)
        else $error("results produced without a transaction");

endmodule

@@ hw/rtl/rds_queue.sv @@
// ----------------------------------------------------------------------------
// rds_queue
// Small result queue: takes up to two results per cycle, hands out one while out_ready is high.
// ----------------------------------------------------------------------------
module rds_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  rds_pkg::push_t   push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output rds_pkg::result_t head
);

    localparam int DEPTH = rds_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    rds_pkg::result_t mem_reg [DEPTH];
    logic [PW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [PW-1:0]    tail;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= CW'(DEPTH - 2));
    assign head      = mem_reg[head_reg];
    assign tail      = head_reg + PW'(count_reg);

    always_comb
    begin
        head_next  = pop ? head_reg + PW'(1) : head_reg;
        count_next = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[tail] <= push.res0;
        if (push.count == 2'd2)
            mem_reg[tail + PW'(1)] <= push.res1;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> 32'(count_reg) + 32'(push.count) <= DEPTH)
        else $error("result queue overflow");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd0 && pop |=> count_reg == $past(count_reg) - CW'(1))
        else $error("queue count lost track of a pop");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> !push.res0.last && push.res1.last)
        else $error("last_result misplaced in result pair");

endmodule
